[design/lvg3d_pkg.sv]
// lvg3d_pkg: types, widths and axis helpers for the 3d line voxel generator
// depends on nothing; used by every module of the block
`timescale 1ns / 1ps

package lvg3d_pkg;

  localparam int COORD_BITS = 6;
  localparam int DELTA_BITS = COORD_BITS + 1;
  localparam int ERR_BITS   = COORD_BITS + 3;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [DELTA_BITS-1:0] delta_t;
  typedef logic signed [ERR_BITS-1:0] err_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t start_z;
    coord_t end_x;
    coord_t end_y;
    coord_t end_z;
  } req_t;

  typedef struct packed {
    coord_t voxel_x;
    coord_t voxel_y;
    coord_t voxel_z;
    logic   last_point;
  } res_t;

  typedef struct packed {
    axis_t                 major;
    logic [2:0]            neg;
    logic [2:0][DELTA_BITS-1:0] twice;
    err_t                  err_first;
    err_t                  err_second;
    coord_t                target;
    logic [2:0][COORD_BITS-1:0] origin;
  } setup_t;

  function automatic axis_t minor_first(axis_t maj);
    axis_t r;
    unique case (maj)
      AXIS_X:  r = AXIS_Y;
      AXIS_Y:  r = AXIS_X;
      AXIS_Z:  r = AXIS_X;
      default: r = AXIS_Y;
    endcase
    return r;
  endfunction

  function automatic axis_t minor_second(axis_t maj);
    axis_t r;
    unique case (maj)
      AXIS_X:  r = AXIS_Z;
      AXIS_Y:  r = AXIS_Z;
      AXIS_Z:  r = AXIS_Y;
      default: r = AXIS_Z;
    endcase
    return r;
  endfunction

  function automatic delta_t pick_delta(logic [2:0][DELTA_BITS-1:0] v, axis_t a);
    delta_t r;
    unique case (a)
      AXIS_X:  r = v[0];
      AXIS_Y:  r = v[1];
      AXIS_Z:  r = v[2];
      default: r = v[0];
    endcase
    return r;
  endfunction

  function automatic coord_t pick_coord(logic [2:0][COORD_BITS-1:0] v, axis_t a);
    coord_t r;
    unique case (a)
      AXIS_X:  r = v[0];
      AXIS_Y:  r = v[1];
      AXIS_Z:  r = v[2];
      default: r = v[0];
    endcase
    return r;
  endfunction

  function automatic err_t widen_delta(delta_t d);
    return $signed({{(ERR_BITS-DELTA_BITS){1'b0}}, d});
  endfunction

endpackage

[design/lvg3d_setup.sv]
// lvg3d_setup: per-line setup, deltas, step signs, major axis, initial errors
// depends on lvg3d_pkg
`timescale 1ns / 1ps

module lvg3d_setup (
  input  lvg3d_pkg::req_t   request,
  output lvg3d_pkg::setup_t setup
);

  logic [2:0][lvg3d_pkg::COORD_BITS-1:0] s_pt;
  logic [2:0][lvg3d_pkg::COORD_BITS-1:0] e_pt;
  logic [2:0][lvg3d_pkg::COORD_BITS-1:0] ad;
  logic [2:0][lvg3d_pkg::DELTA_BITS-1:0] tw;
  logic [2:0]                            neg;
  lvg3d_pkg::axis_t                      maj;
  lvg3d_pkg::err_t                       half_major;

  always_comb begin
    s_pt = {request.start_z, request.start_y, request.start_x};
    e_pt = {request.end_z, request.end_y, request.end_x};
    for (int i = 0; i < 3; i++) begin
      neg[i] = e_pt[i] < s_pt[i];
      ad[i]  = neg[i] ? (s_pt[i] - e_pt[i]) : (e_pt[i] - s_pt[i]);
      tw[i]  = {ad[i], 1'b0};
    end

    priority if (tw[0] >= tw[1] && tw[0] >= tw[2]) begin
      maj = lvg3d_pkg::AXIS_X;
    end else if (tw[1] >= tw[2]) begin
      maj = lvg3d_pkg::AXIS_Y;
    end else begin
      maj = lvg3d_pkg::AXIS_Z;
    end

    half_major = $signed({3'b000, lvg3d_pkg::pick_coord(ad, maj)});

    setup.major      = maj;
    setup.neg        = neg;
    setup.twice      = tw;
    setup.err_first  = lvg3d_pkg::widen_delta(
                         lvg3d_pkg::pick_delta(tw, lvg3d_pkg::minor_first(maj))) - half_major;
    setup.err_second = lvg3d_pkg::widen_delta(
                         lvg3d_pkg::pick_delta(tw, lvg3d_pkg::minor_second(maj))) - half_major;
    setup.target     = lvg3d_pkg::pick_coord(e_pt, maj);
    setup.origin     = s_pt;
  end

endmodule

[design/lvg3d_stepper.sv]
// lvg3d_stepper: shared step unit, current voxel and error terms, one step a cycle while advance is high
// depends on lvg3d_pkg
`timescale 1ns / 1ps

module lvg3d_stepper (
  input  logic                                  clk,
  input  logic                                  load,
  input  logic                                  advance,
  input  lvg3d_pkg::setup_t                     setup,
  output logic [2:0][lvg3d_pkg::COORD_BITS-1:0] pos,
  output logic                                  last
);

  lvg3d_pkg::axis_t                      major;
  logic [2:0]                            neg;
  logic [2:0][lvg3d_pkg::DELTA_BITS-1:0] twice;
  lvg3d_pkg::err_t                       err_first;
  lvg3d_pkg::err_t                       err_second;
  lvg3d_pkg::coord_t                     target;

  lvg3d_pkg::axis_t                      m1;
  lvg3d_pkg::axis_t                      m2;
  lvg3d_pkg::err_t                       a_maj;
  logic                                  step1;
  logic                                  step2;
  logic [2:0]                            move;
  logic [2:0][lvg3d_pkg::COORD_BITS-1:0] pos_next;
  lvg3d_pkg::err_t                       err_first_next;
  lvg3d_pkg::err_t                       err_second_next;

  always_comb begin
    m1    = lvg3d_pkg::minor_first(major);
    m2    = lvg3d_pkg::minor_second(major);
    a_maj = lvg3d_pkg::widen_delta(lvg3d_pkg::pick_delta(twice, major));
    step1 = !err_first[lvg3d_pkg::ERR_BITS-1];
    step2 = !err_second[lvg3d_pkg::ERR_BITS-1];
    err_first_next  = err_first - (step1 ? a_maj : '0)
                    + lvg3d_pkg::widen_delta(lvg3d_pkg::pick_delta(twice, m1));
    err_second_next = err_second - (step2 ? a_maj : '0)
                    + lvg3d_pkg::widen_delta(lvg3d_pkg::pick_delta(twice, m2));
    for (int i = 0; i < 3; i++) begin
      move[i] = (2'(i) == major) || (2'(i) == m1 && step1) || (2'(i) == m2 && step2);
      pos_next[i] = pos[i];
      if (move[i]) begin
        pos_next[i] = neg[i] ? (pos[i] - 1'b1) : (pos[i] + 1'b1);
      end
    end
    last = lvg3d_pkg::pick_coord(pos, major) == target;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      major      <= setup.major;
      neg        <= setup.neg;
      twice      <= setup.twice;
      err_first  <= setup.err_first;
      err_second <= setup.err_second;
      target     <= setup.target;
      pos        <= setup.origin;
    end else if (advance) begin
      err_first  <= err_first_next;
      err_second <= err_second_next;
      pos        <= pos_next;
    end
  end

endmodule

[design/line_voxel_generator_3d.sv]
// line_voxel_generator_3d: top level, sequencer and result register
// depends on lvg3d_pkg, lvg3d_setup, lvg3d_stepper
//
//   channel   handshake         payload            direction
//   request   start / busy      request (req_t)    in
//   result    strobe            result (res_t)     out
//
// a line of N voxels (N = max |delta| + 1, at most 64) keeps busy high from the
// accepting edge through its last step, one voxel stepped per cycle by the
// shared step unit; a new item is taken only once busy has dropped, in idle.
// each voxel is registered into result and shows for one cycle.
// rst is synchronous; it returns the block to idle with no strobe.
// the receiver cannot stall, so nothing is held back on the result side.
`timescale 1ns / 1ps

module line_voxel_generator_3d (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  lvg3d_pkg::req_t request,
  output logic            strobe,
  output lvg3d_pkg::res_t result
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_t;

  state_t                                state;
  state_t                                state_next;
  lvg3d_pkg::setup_t                     setup;
  logic [2:0][lvg3d_pkg::COORD_BITS-1:0] pos;
  logic                                  last;
  logic                                  accept;
  logic                                  walking;

  lvg3d_setup u_setup (
    .request (request),
    .setup   (setup)
  );

  lvg3d_stepper u_stepper (
    .clk     (clk),
    .load    (accept),
    .advance (walking && !last),
    .setup   (setup),
    .pos     (pos),
    .last    (last)
  );

  assign walking = state == ST_WALK;
  assign busy    = walking;
  assign accept  = start && !busy;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_WALK;
      end
      ST_WALK: begin
        if (last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= walking;
    end
  end

  always_ff @(posedge clk) begin
    if (walking) begin
      result.voxel_x    <= pos[0];
      result.voxel_y    <= pos[1];
      result.voxel_z    <= pos[2];
      result.last_point <= last;
    end
  end

  a_strobe_from_walk: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(walking))
    else $error("strobe without a walk step");

  a_accept_starts_walk: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted item did not start a walk");

  a_last_ends_walk: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.last_point) |-> !busy)
    else $error("walk continues after last voxel");

  a_mid_keeps_walk: assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.last_point) |-> busy)
    else $error("walk ended before last voxel");

endmodule

[bench/tb_line_voxel_generator_3d.sv]
// tb_line_voxel_generator_3d: self-checking bench for the 3d line voxel generator
// walks every line with its own bresenham predictor and checks each voxel in order
// depends on lvg3d_pkg and line_voxel_generator_3d
`timescale 1ns / 1ps

module tb_line_voxel_generator_3d;

  logic            clk;
  logic            rst = 1'b1;
  logic            start = 1'b0;
  logic            busy;
  lvg3d_pkg::req_t request = '0;
  logic            strobe;
  lvg3d_pkg::res_t result;

  lvg3d_pkg::res_t line_voxels_due[$];
  int              mismatch_count = 0;
  bit              no_gaps = 1'b0;

  line_voxel_generator_3d DUT (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .strobe  (strobe),
    .result  (result)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    #2_400_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // bresenham walk of one line, appended to the voxels still due
  function automatic void trace_line(lvg3d_pkg::req_t req);
    int               p[3];
    int               e[3];
    int               d2[3];
    int               dir[3];
    lvg3d_pkg::axis_t maj;
    int               mj;
    int               m1;
    int               m2;
    int               err1;
    int               err2;
    int               count;
    bit               at_end;
    lvg3d_pkg::res_t  v;
    p[0] = req.start_x;
    p[1] = req.start_y;
    p[2] = req.start_z;
    e[0] = req.end_x;
    e[1] = req.end_y;
    e[2] = req.end_z;
    for (int i = 0; i < 3; i++) begin
      d2[i]  = (e[i] < p[i]) ? 2 * (p[i] - e[i]) : 2 * (e[i] - p[i]);
      dir[i] = (e[i] < p[i]) ? -1 : 1;
    end
    if (d2[0] >= d2[1] && d2[0] >= d2[2]) begin
      maj = lvg3d_pkg::AXIS_X;
    end else if (d2[1] >= d2[2]) begin
      maj = lvg3d_pkg::AXIS_Y;
    end else begin
      maj = lvg3d_pkg::AXIS_Z;
    end
    mj = int'(maj);
    case (maj)
      lvg3d_pkg::AXIS_X: begin
        m1 = 1;
        m2 = 2;
      end
      lvg3d_pkg::AXIS_Y: begin
        m1 = 0;
        m2 = 2;
      end
      default: begin
        m1 = 0;
        m2 = 1;
      end
    endcase
    err1  = d2[m1] - d2[mj] / 2;
    err2  = d2[m2] - d2[mj] / 2;
    count = 0;
    forever begin
      at_end       = (p[mj] == e[mj]);
      v.voxel_x    = lvg3d_pkg::coord_t'(p[0]);
      v.voxel_y    = lvg3d_pkg::coord_t'(p[1]);
      v.voxel_z    = lvg3d_pkg::coord_t'(p[2]);
      v.last_point = at_end;
      line_voxels_due.insert(line_voxels_due.size(), v);
      count++;
      if (at_end || count >= (1 << lvg3d_pkg::COORD_BITS)) break;
      if (err1 >= 0) begin
        p[m1] += dir[m1];
        err1  -= d2[mj];
      end
      if (err2 >= 0) begin
        p[m2] += dir[m2];
        err2  -= d2[mj];
      end
      p[mj] += dir[mj];
      err1  += d2[m1];
      err2  += d2[m2];
    end
  endfunction

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $realtime, what);
  endtask

  always @(posedge clk) begin
    lvg3d_pkg::res_t want;
    if (!rst && strobe) begin
      if (line_voxels_due.size() == 0) begin
        report_mismatch($sformatf("unexpected voxel (%0d,%0d,%0d) last=%0b",
                        result.voxel_x, result.voxel_y, result.voxel_z,
                        result.last_point));
      end else begin
        want = line_voxels_due.pop_front();
        if (result.voxel_x !== want.voxel_x || result.voxel_y !== want.voxel_y ||
            result.voxel_z !== want.voxel_z || result.last_point !== want.last_point)
          report_mismatch($sformatf("voxel exp (%0d,%0d,%0d) last=%0b got (%0d,%0d,%0d) last=%0b",
                          want.voxel_x, want.voxel_y, want.voxel_z, want.last_point,
                          result.voxel_x, result.voxel_y, result.voxel_z,
                          result.last_point));
      end
    end
  end

  // start stays high after acceptance so a zero gap keeps it high
  task automatic send_request(lvg3d_pkg::req_t req);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    request <= req;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    trace_line(req);
  endtask

  task automatic send_line(int sx, int sy, int sz, int ex, int ey, int ez);
    lvg3d_pkg::req_t req;
    req.start_x = lvg3d_pkg::coord_t'(sx);
    req.start_y = lvg3d_pkg::coord_t'(sy);
    req.start_z = lvg3d_pkg::coord_t'(sz);
    req.end_x   = lvg3d_pkg::coord_t'(ex);
    req.end_y   = lvg3d_pkg::coord_t'(ey);
    req.end_z   = lvg3d_pkg::coord_t'(ez);
    send_request(req);
  endtask

  task automatic wait_lines_done();
    start <= 1'b0;
    while (line_voxels_due.size() > 0) @(posedge clk);
  endtask

  // mostly short lines, some across the whole cube, some axes held flat
  function automatic lvg3d_pkg::req_t make_random_line();
    lvg3d_pkg::req_t req;
    int              s[3];
    int              t[3];
    int              reach;
    reach = ($urandom_range(0, 3) == 0) ? 63 : $urandom_range(0, 8);
    for (int i = 0; i < 3; i++) begin
      s[i] = $urandom_range(0, 63);
      if ($urandom_range(0, 3) == 0) begin
        t[i] = s[i];
      end else if (reach == 63) begin
        t[i] = $urandom_range(0, 63);
      end else begin
        t[i] = s[i] + $urandom_range(0, 2 * reach) - reach;
        if (t[i] < 0) t[i] = 0;
        if (t[i] > 63) t[i] = 63;
      end
    end
    req.start_x = lvg3d_pkg::coord_t'(s[0]);
    req.start_y = lvg3d_pkg::coord_t'(s[1]);
    req.start_z = lvg3d_pkg::coord_t'(s[2]);
    req.end_x   = lvg3d_pkg::coord_t'(t[0]);
    req.end_y   = lvg3d_pkg::coord_t'(t[1]);
    req.end_z   = lvg3d_pkg::coord_t'(t[2]);
    return req;
  endfunction

  task automatic test_directed_lines();
    send_line(0, 0, 0, 0, 0, 0);
    send_line(63, 63, 63, 63, 63, 63);
    send_line(0, 0, 0, 63, 63, 63);
    send_line(63, 63, 63, 0, 0, 0);
    send_line(0, 0, 0, 63, 0, 0);
    send_line(0, 63, 0, 0, 0, 0);
    send_line(0, 0, 0, 0, 0, 63);
    send_line(0, 0, 0, 63, 20, 41);
    send_line(10, 0, 5, 3, 63, 30);
    send_line(60, 50, 63, 40, 33, 0);
    send_line(5, 5, 5, 15, 15, 0);
    send_line(5, 5, 5, 0, 15, 15);
    send_line(5, 5, 5, 15, 0, 15);
    send_line(32, 32, 32, 33, 32, 32);
    send_line(32, 32, 32, 31, 31, 31);
    send_line(0, 63, 0, 63, 0, 63);
    send_line(63, 0, 63, 0, 63, 0);
    send_line(1, 2, 3, 2, 4, 7);
    send_line(0, 0, 0, 1, 62, 31);
    send_line(42, 21, 0, 21, 42, 63);
  endtask

  task automatic test_random_lines(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 15) == 0) no_gaps = ~no_gaps;
      send_request(make_random_line());
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_back_to_back();
    no_gaps = 1'b1;
    for (int i = 0; i < 20; i++) send_request(make_random_line());
    no_gaps = 1'b0;
  endtask

  task automatic test_drain_between_lines();
    for (int i = 0; i < 10; i++) begin
      send_request(make_random_line());
      if (i % 3 == 2) wait_lines_done();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed_lines();
    test_random_lines(100);
    test_drain_between_lines();
    test_back_to_back();
    test_random_lines(100);
    wait_lines_done();
    repeat (70) @(posedge clk);
    if (mismatch_count == 0 && line_voxels_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
design/lvg3d_pkg.sv
design/lvg3d_setup.sv
design/lvg3d_stepper.sv
design/line_voxel_generator_3d.sv
bench/tb_line_voxel_generator_3d.sv
